// ----- hw/rtl/hptu_pkg.sv -----
// Shared types and constants for the homogeneous point transform unit.
// No dependencies; imported by every module of the block.
package hptu_pkg;

  // default parameter values
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;
  localparam int unsigned POINT_BITS_DEF     = 16;

  // fixed field widths
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned QUO_W   = 32;
  localparam int unsigned CNT_W   = $clog2(QUO_W);

  // matrix geometry
  localparam int unsigned MAT_DIM   = 3;
  localparam int unsigned NUM_COEF  = MAT_DIM * MAT_DIM;
  localparam int unsigned NUM_LANES = 2;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  // saturation limits
  localparam logic [QUO_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] LIM_NEG = 32'h8000_0000;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul_x;
    logic mul_y;
    logic sum;
    logic prep;
    logic check;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/hptu_ctrl.sv -----
// Sequencer for the homogeneous point transform unit.
// Depends on hptu_pkg; drives the command struct of hptu_dp.
module hptu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          action_i,
  input  hptu_pkg::sts_t sts_i,
  output hptu_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import hptu_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MULX  = 8'b0000_0010,
    ST_MULY  = 8'b0000_0100,
    ST_SUM   = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_XFORM) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MULX;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- hw/rtl/hptu_dp.sv -----
// Datapath: coefficient store, three MAC lanes, two-lane restoring divider
// and output register. Depends on hptu_pkg; controlled by hptu_ctrl.
module hptu_dp #(
  parameter int unsigned COEF_FRAC_BITS = hptu_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned POINT_BITS     = hptu_pkg::POINT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hptu_pkg::cmd_t                     cmd_i,
  output hptu_pkg::sts_t                     sts_o,
  input  logic signed [POINT_BITS-1:0]       point_x_i,
  input  logic signed [POINT_BITS-1:0]       point_y_i,
  input  logic [hptu_pkg::IDX_W-1:0]         coef_index_i,
  input  logic signed [hptu_pkg::COEF_W-1:0] coef_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [hptu_pkg::QUO_W-1:0]  out_x_o,
  output logic signed [hptu_pkg::QUO_W-1:0]  out_y_o,
  output logic                               divisor_zero_o,
  output logic                               saturated_o
);
  import hptu_pkg::*;

  localparam int unsigned PW = POINT_BITS + COEF_W;     // product
  localparam int unsigned SW = POINT_BITS + COEF_W + 1; // column sum
  localparam int unsigned MW = POINT_BITS + COEF_W;     // sum magnitude
  localparam int unsigned OW = MW + QUO_W - COEF_FRAC_BITS;
  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) << COEF_FRAC_BITS;

  logic signed [POINT_BITS-1:0] px_q, py_q;
  logic signed [COEF_W-1:0]     coef_q [NUM_COEF];
  logic signed [PW-1:0]         prod_q [MAT_DIM];
  logic signed [SW-1:0]         acc_q  [MAT_DIM];

  logic [MW-1:0]    num_q [NUM_LANES];
  logic [MW-1:0]    den_q;
  logic             neg_q [NUM_LANES];
  logic             ovf_q [NUM_LANES];
  logic             wzero_q;
  logic [MW-1:0]    rem_q  [NUM_LANES];
  logic [QUO_W-1:0] dlow_q [NUM_LANES];
  logic [QUO_W-1:0] quo_q  [NUM_LANES];
  logic [CNT_W-1:0] cnt_q;

  logic                     out_valid_q;
  logic signed [QUO_W-1:0]  out_x_q, out_y_q;
  logic                     dz_q, sat_q;

  // multiplier operands per column lane
  logic signed [POINT_BITS-1:0] op_pt;
  logic signed [COEF_W-1:0]     op_cf [MAT_DIM];

  // divider step and result shaping
  logic [MW:0]      trial [NUM_LANES];
  logic             fits  [NUM_LANES];
  logic [QUO_W-1:0] res   [NUM_LANES];
  logic             lsat  [NUM_LANES];

  assign op_pt = cmd_i.mul_y ? py_q : px_q;

  always_comb begin
    for (int c = 0; c < MAT_DIM; c++) begin
      op_cf[c] = cmd_i.mul_y ? coef_q[MAT_DIM + c] : coef_q[c];
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      trial[l] = {rem_q[l], dlow_q[l][QUO_W-1]};
      fits[l]  = (trial[l] >= {1'b0, den_q});
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lsat[l] = 1'b0;
      if (ovf_q[l]) begin
        res[l]  = neg_q[l] ? LIM_NEG : LIM_POS;
        lsat[l] = 1'b1;
      end else if (neg_q[l]) begin
        if (quo_q[l][QUO_W-1] && (quo_q[l][QUO_W-2:0] != '0)) begin
          res[l]  = LIM_NEG;
          lsat[l] = 1'b1;
        end else begin
          res[l] = -quo_q[l];
        end
      end else if (quo_q[l][QUO_W-1]) begin
        res[l]  = LIM_POS;
        lsat[l] = 1'b1;
      end else begin
        res[l] = quo_q[l];
      end
    end
  end

  // coefficient store, identity at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= ((i % (MAT_DIM + 1)) == 0) ? ONE : '0;
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        if (coef_index_i == IDX_W'(i)) begin
          coef_q[i] <= coef_value_i;
        end
      end
    end
  end

  // arithmetic payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
    if (cmd_i.mul_x || cmd_i.mul_y) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        prod_q[c] <= op_pt * op_cf[c];
      end
    end
    if (cmd_i.mul_y) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        acc_q[c] <= SW'(coef_q[2*MAT_DIM + c]) + SW'(prod_q[c]);
      end
    end
    if (cmd_i.sum) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        acc_q[c] <= acc_q[c] + SW'(prod_q[c]);
      end
    end
    if (cmd_i.prep) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        num_q[l] <= acc_q[l][SW-1] ? MW'(-acc_q[l]) : MW'(acc_q[l]);
        neg_q[l] <= acc_q[l][SW-1] ^ acc_q[MAT_DIM-1][SW-1];
      end
      den_q   <= acc_q[MAT_DIM-1][SW-1] ? MW'(-acc_q[MAT_DIM-1]) : MW'(acc_q[MAT_DIM-1]);
      wzero_q <= (acc_q[MAT_DIM-1] == '0);
    end
    if (cmd_i.check) begin
      // quotient of 2^32 or more clamps whatever the low bits
      for (int l = 0; l < NUM_LANES; l++) begin
        ovf_q[l]  <= OW'(num_q[l]) >= (OW'(den_q) << (QUO_W - COEF_FRAC_BITS));
        rem_q[l]  <= MW'(num_q[l] >> (QUO_W - COEF_FRAC_BITS));
        dlow_q[l] <= QUO_W'(num_q[l] << COEF_FRAC_BITS);
        quo_q[l]  <= '0;
      end
      cnt_q <= CNT_W'(QUO_W - 1);
    end
    if (cmd_i.div_step) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_q[l]  <= fits[l] ? MW'(trial[l] - {1'b0, den_q}) : MW'(trial[l]);
        quo_q[l]  <= {quo_q[l][QUO_W-2:0], fits[l]};
        dlow_q[l] <= {dlow_q[l][QUO_W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.finish) begin
      out_x_q <= wzero_q ? '0 : res[0];
      out_y_q <= wzero_q ? '0 : res[1];
      dz_q    <= wzero_q;
      sat_q   <= !wzero_q && (lsat[0] || lsat[1]);
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign divisor_zero_o = dz_q;
  assign saturated_o    = sat_q;

endmodule

// ----- hw/rtl/homogeneous_point_transform_unit.sv -----
// Projective 2D point transform by a 3x3 matrix of signed Q16.16 coefficients
// (depends on hptu_pkg, hptu_ctrl, hptu_dp). A load word (action 0) writes one
// coefficient, entry row*3+col; indexes 9 to 15 write nothing, and the matrix
// is the identity after reset. A transform word (action 1) takes (x, y, 1)
// times the matrix and divides the first two column sums by the third, giving
// Q16.16 results truncated toward zero, clamped with the saturated flag, or
// zero with divisor_zero set when w is zero. A transform runs in order through
// multiply-accumulate in three column lanes (MULX, MULY, SUM), divider set-up
// (PREP, CHECK), 32 steps of a restoring divider that works both quotients in
// parallel lanes against the shared divisor, and a final step that shapes the
// result into the result register. The next word is taken while a result
// still waits at the output; a result is held back only while the previous
// one has not been taken.
module homogeneous_point_transform_unit #(
  parameter int unsigned COEF_FRAC_BITS = hptu_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned POINT_BITS     = hptu_pkg::POINT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic signed [POINT_BITS-1:0]       point_x_i,
  input  logic signed [POINT_BITS-1:0]       point_y_i,
  input  logic [hptu_pkg::IDX_W-1:0]         coef_index_i,
  input  logic signed [hptu_pkg::COEF_W-1:0] coef_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [hptu_pkg::QUO_W-1:0]  out_x_o,
  output logic signed [hptu_pkg::QUO_W-1:0]  out_y_o,
  output logic                               divisor_zero_o,
  output logic                               saturated_o
);
  import hptu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hptu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  hptu_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .POINT_BITS     (POINT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .divisor_zero_o (divisor_zero_o),
    .saturated_o    (saturated_o)
  );

endmodule

// ----- hw/rtl/hptu_chk.sv -----
// Port-level checks for homogeneous_point_transform_unit, bound to the top.
// Depends on hptu_pkg.
module hptu_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              action_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [hptu_pkg::QUO_W-1:0]        out_x_o,
  input logic [hptu_pkg::QUO_W-1:0]        out_y_o,
  input logic                              divisor_zero_o,
  input logic                              saturated_o
);
  import hptu_pkg::*;

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o))
    else $error("output word changed while stalled");

  // a transform word keeps the block busy on the next cycle
  a_xform_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_XFORM) |=> in_stall_o)
    else $error("block free right after a transform word");

  // a load word never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a load word");

  // zero divisor forces zero outputs and no clamp flag
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divisor_zero_o |-> (out_x_o == '0) && (out_y_o == '0) && !saturated_o)
    else $error("zero divisor result not cleared");

  // a new result only ever comes out of a busy period
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transform in progress");

endmodule

bind homogeneous_point_transform_unit hptu_chk u_hptu_chk (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for homogeneous_point_transform_unit: coefficient loads and point
// transforms in directed then random order, checked against a scoreboard-held predictor.
// Depends on hptu_pkg and the RTL of the block only.
module testbench;
  import hptu_pkg::*;

  localparam int unsigned FRAC = COEF_FRAC_BITS_DEF;
  localparam int unsigned PW   = POINT_BITS_DEF;
  localparam int unsigned IW   = IDX_W;
  localparam logic signed [COEF_W-1:0] ONE = 32'sd1 <<< FRAC;

  localparam logic [IW-1:0] M00 = 4'd0, M02 = 4'd2, M10 = 4'd3, M22 = 4'd8;

  localparam int unsigned WORD_TARGET = 850;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef enum int unsigned {SH_AFFINE, SH_PERSP, SH_FLAT_W, SH_STEEP, SH_WILD} mat_shape_e;

  typedef struct packed {
    logic signed [QUO_W-1:0] x;
    logic signed [QUO_W-1:0] y;
    logic                    dz;
    logic                    sat;
  } point_out_t;

  class point_scoreboard;
    int signed   coef_q[NUM_COEF];
    point_out_t  due_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] = (i % 4 == 0) ? ONE : 0;
    endfunction

    // Q16.16 quotient, truncated toward zero, clamped to 32 bits
    function automatic logic [QUO_W-1:0] fix_quot(input longint num, input longint den,
                                                  output bit clamped);
      longint unsigned a, d, q, r, full, lim;
      bit neg;
      a = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      neg = (num < 0) != (den < 0);
      q = a / d;
      r = a % d;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (q >= (64'd1 << (32 - FRAC))) begin
        full = lim + 1;
      end else begin
        full = q;
        for (int i = 0; i < FRAC; i++) begin
          r = r << 1;
          full = full << 1;
          if (r >= d) begin
            r = r - d;
            full = full | 64'd1;
          end
        end
      end
      clamped = full > lim;
      if (clamped) full = lim;
      if (neg) full = -full;
      return full[QUO_W-1:0];
    endfunction

    function automatic point_out_t project_point(input logic signed [PW-1:0] px,
                                                 input logic signed [PW-1:0] py);
      longint s[3];
      bit cx, cy;
      point_out_t res;
      for (int c = 0; c < 3; c++)
        s[c] = longint'(px) * longint'(coef_q[c]) + longint'(py) * longint'(coef_q[3+c])
             + longint'(coef_q[6+c]);
      if (s[2] == 0) begin
        res = '{x: '0, y: '0, dz: 1'b1, sat: 1'b0};
      end else begin
        res.x = fix_quot(s[0], s[2], cx);
        res.y = fix_quot(s[1], s[2], cy);
        res.dz = 1'b0;
        res.sat = cx | cy;
      end
      return res;
    endfunction

    function void take_word(input logic act, input logic signed [PW-1:0] px,
                            input logic signed [PW-1:0] py, input logic [IW-1:0] idx,
                            input logic signed [COEF_W-1:0] val);
      if (act == ACT_LOAD) begin
        if (idx < NUM_COEF) coef_q[idx] = val;
      end else begin
        due_q.push_back(project_point(px, py));
      end
    endfunction

    function void check_point(input logic signed [QUO_W-1:0] gx,
                              input logic signed [QUO_W-1:0] gy, input logic gdz,
                              input logic gsat);
      point_out_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h dz=%b sat=%b", $time, gx, gy, gdz, gsat);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (gx !== want.x) begin
        $display("%0t: out_x expected %h, got %h", $time, want.x, gx);
        errors++;
      end
      if (gy !== want.y) begin
        $display("%0t: out_y expected %h, got %h", $time, want.y, gy);
        errors++;
      end
      if (gdz !== want.dz) begin
        $display("%0t: divisor_zero expected %b, got %b", $time, want.dz, gdz);
        errors++;
      end
      if (gsat !== want.sat) begin
        $display("%0t: saturated expected %b, got %b", $time, want.sat, gsat);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      action_i = ACT_LOAD;
  logic signed [PW-1:0]      point_x_i = '0;
  logic signed [PW-1:0]      point_y_i = '0;
  logic [IW-1:0]             coef_index_i = '0;
  logic signed [COEF_W-1:0]  coef_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [QUO_W-1:0]   out_x_o;
  logic signed [QUO_W-1:0]   out_y_o;
  logic                      divisor_zero_o;
  logic                      saturated_o;

  point_scoreboard chk = new();
  int unsigned     words_counted = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     stall_run = 0;
  bit              calm_phase = 1'b0;
  bit              draining = 1'b0;

  homogeneous_point_transform_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .divisor_zero_o(divisor_zero_o),
    .saturated_o   (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // mostly short, now and then long enough to cover a whole transform
  function automatic int unsigned spread_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(40, 150);
  endfunction

  function automatic int signed signed_upto(input int unsigned m);
    return int'($urandom_range(0, 2 * m)) - int'(m);
  endfunction

  function automatic logic signed [COEF_W-1:0] any_coef();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom_range(0, 1) ? ONE : -ONE;
      3: return signed_upto(1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_for(input mat_shape_e shape,
                                                       input logic [IW-1:0] idx);
    bit wcol;
    wcol = (idx % 3) == 2;
    case (shape)
      SH_AFFINE: return wcol ? ((idx == M22) ? ONE : 32'sd0) : signed_upto(1 << 19);
      SH_PERSP:  return wcol ? ((idx == M22) ? signed_upto(1 << 19) : signed_upto(512))
                             : signed_upto(1 << 19);
      SH_FLAT_W: return wcol ? 32'sd0 : any_coef();
      SH_STEEP:  return wcol ? ((idx == M22) ? signed_upto(16) : 32'sd0) : any_coef();
      default:   return any_coef();
    endcase
  endfunction

  function automatic logic signed [PW-1:0] point_for();
    case ($urandom_range(0, 9))
      0, 1: return PW'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(PW-1){1'b0}}};
          1: return {1'b0, {(PW-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return PW'(1);
        endcase
      end
      default: return PW'(signed_upto(200));
    endcase
  endfunction

  // present one word, hold it until taken; valid stays up when no gap follows
  task automatic put_word(input logic act, input logic signed [PW-1:0] px,
                          input logic signed [PW-1:0] py, input logic [IW-1:0] idx,
                          input logic signed [COEF_W-1:0] val);
    int unsigned gap;
    gap = (calm_phase || $urandom_range(0, 1)) ? 0 : spread_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i     <= act;
    point_x_i    <= px;
    point_y_i    <= py;
    coef_index_i <= idx;
    coef_value_i <= val;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    chk.take_word(act, px, py, idx, val);
    if (act == ACT_XFORM || idx < NUM_COEF) words_counted++;
  endtask

  task automatic load(input logic [IW-1:0] idx, input logic signed [COEF_W-1:0] val);
    put_word(ACT_LOAD, PW'($urandom), PW'($urandom), idx, val);
  endtask

  task automatic xform(input logic signed [PW-1:0] px, input logic signed [PW-1:0] py);
    put_word(ACT_XFORM, px, py, IW'($urandom), $urandom);
  endtask

  task automatic directed_words();
    xform(0, 0);
    xform(16'sh7FFF, 16'sh7FFF);
    xform(16'sh8000, 16'sh8000);
    xform(16'sh8000, 16'sh7FFF);
    // indexes past the matrix write nothing
    load(IW'(NUM_COEF), $urandom);
    load('1, $urandom);
    xform(5, -3);
    load(M22, 0);
    xform(5, 7);
    xform(0, 0);
    // w of one lsb forces a clamp unless the numerator is zero
    load(M22, 1);
    xform(3, -4);
    xform(0, 0);
    load(M22, -ONE);
    xform(-7, 9);
    load(M22, 3 * ONE);
    xform(1, -1);
    load(M00, 32'sh8000_0000);
    load(M10, 32'sh7FFF_FFFF);
    load(M22, ONE);
    xform(16'sh8000, 16'sh7FFF);
    load(M02, 32'sh7FFF_FFFF);
    xform(1, 0);
    load(M00, ONE);
    load(M10, 0);
    load(M02, 0);
  endtask

  task automatic random_words();
    mat_shape_e shape;
    while (words_counted < WORD_TARGET) begin
      calm_phase <= ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 6) == 0) begin
        // noise: any word at all
        put_word(1'($urandom_range(0, 1)), PW'($urandom), PW'($urandom),
                 IW'($urandom_range(0, 15)), $urandom);
      end else begin
        shape = mat_shape_e'($urandom_range(0, 4));
        if ($urandom_range(0, 1)) begin
          for (int i = 0; i < NUM_COEF; i++) load(IW'(i), coef_for(shape, IW'(i)));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            automatic logic [IW-1:0] idx = IW'($urandom_range(0, NUM_COEF - 1));
            load(idx, coef_for(shape, idx));
          end
        end
        if ($urandom_range(0, 7) == 0) load(IW'($urandom_range(NUM_COEF, 15)), $urandom);
        repeat ($urandom_range(1, 6)) xform(point_for(), point_for());
      end
    end
  endtask

  // result side: random stall runs, checking on every taken word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        chk.check_point(out_x_o, out_y_o, divisor_zero_o, saturated_o);
      if (stall_run == 0 && !calm_phase && !draining && $urandom_range(0, 3) == 0)
        stall_run = spread_len();
      out_stall_i <= (stall_run != 0);
      if (stall_run != 0) stall_run--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    random_words();
    in_valid_i <= 1'b0;
    while (chk.due_q.size() != 0) @(posedge clk_i);
    draining <= 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (chk.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
